// ===== rtl/core/pdfi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfi_pkg: shared types and constants of the direction field interpolator
// Holds widths, status and register codes, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pdfi_pkg;

	localparam int MAX_VERTICES_DEF = 256;

	typedef logic signed [15:0] coord_t;
	typedef logic signed [15:0] angle_t;
	typedef logic [1:0]         status_t;
	typedef logic [1:0]         cfg_idx_t;

	// register indexes
	localparam cfg_idx_t CFG_ORIGIN_X     = 2'd0;
	localparam cfg_idx_t CFG_ORIGIN_Y     = 2'd1;
	localparam cfg_idx_t CFG_FIELD_WIDTH  = 2'd2;
	localparam cfg_idx_t CFG_FIELD_HEIGHT = 2'd3;

	// result status codes
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	// command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam int                 CORDIC_ITERS = 17;
	localparam logic signed [19:0] HALF_PI_Q16  = 20'sd102944;
	localparam logic signed [19:0] ANGLE_MAX    = 20'sd25736;

	// atan(2^-i) in Q0.16
	function automatic logic [15:0] cordic_atan(input logic [4:0] i);
		logic [15:0] r;
		unique case (i)
			5'd0:    r = 16'd51472;
			5'd1:    r = 16'd30386;
			5'd2:    r = 16'd16055;
			5'd3:    r = 16'd8150;
			5'd4:    r = 16'd4091;
			5'd5:    r = 16'd2047;
			5'd6:    r = 16'd1024;
			5'd7:    r = 16'd512;
			5'd8:    r = 16'd256;
			5'd9:    r = 16'd128;
			5'd10:   r = 16'd64;
			5'd11:   r = 16'd32;
			5'd12:   r = 16'd16;
			5'd13:   r = 16'd8;
			5'd14:   r = 16'd4;
			5'd15:   r = 16'd2;
			5'd16:   r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pdfi_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfi_if: channel interfaces of the direction field interpolator
// Request, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdfi_req_if import pdfi_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   command;
	coord_t coord_x;
	coord_t coord_y;
	logic   last_point;
	modport source (output valid, command, coord_x, coord_y, last_point, input ready);
	modport sink   (input valid, command, coord_x, coord_y, last_point, output ready);
endinterface

interface pdfi_rsp_if import pdfi_pkg::*; ();
	logic    valid;
	logic    ready;
	angle_t  angle;
	status_t status;
	modport source (output valid, angle, status, input ready);
	modport sink   (input valid, angle, status, output ready);
endinterface

interface pdfi_cfg_if import pdfi_pkg::*; ();
	logic        valid;
	logic        ready;
	cfg_idx_t    index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pdfi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfi_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pdfi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/polyline_direction_field_interp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_direction_field_interp_core: hint polyline direction field
// Loads polyline vertices with CORDIC segment angles and answers queries with
// the inverse-distance weighted angle of the two nearest vertices.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  req     | in  | command, coord_x, coord_y, last_point
//  rsp     | out | angle, status (one per request word)
//  cfg     | in  | index, data (always ready)
//
//  A load runs no CORDIC for the first vertex and 17 CORDIC steps for any
//  other, through one shift/add unit. A query scans the N stored vertices
//  with a read, square x, square y and compare step per vertex through one
//  multiplier, then runs two 26-step square roots and a 43-step restoring
//  divide; the divide is skipped when both distances are zero.
//  Reset clears control state and sets the configuration registers; the vertex RAMs need no clearing.
//  The result register lets the next request enter while a result waits.
// ----------------------------------------------------------------------------
module polyline_direction_field_interp_core import pdfi_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pdfi_req_if.sink   req,
	pdfi_rsp_if.source rsp,
	pdfi_cfg_if.sink   cfg
);
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = AW + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CORD = 4'd1;
	localparam logic [3:0] S_WA0  = 4'd2;
	localparam logic [3:0] S_WA1  = 4'd3;
	localparam logic [3:0] S_QRD  = 4'd4;
	localparam logic [3:0] S_QMX  = 4'd5;
	localparam logic [3:0] S_QMY  = 4'd6;
	localparam logic [3:0] S_QCMP = 4'd7;
	localparam logic [3:0] S_QA1  = 4'd8;
	localparam logic [3:0] S_QA2  = 4'd9;
	localparam logic [3:0] S_SQRT = 4'd10;
	localparam logic [3:0] S_M1   = 4'd11;
	localparam logic [3:0] S_M2   = 4'd12;
	localparam logic [3:0] S_M3   = 4'd13;
	localparam logic [3:0] S_DIV  = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	localparam logic [5:0] SQRT_STEPS = 6'd26;
	localparam logic [5:0] DIV_STEPS  = 6'd43;

	logic [3:0] state_q;
	logic [5:0] iter_q;

	// configuration registers
	logic signed [15:0] origin_x_q, origin_y_q;
	logic [15:0]        field_w_q, field_h_q;

	// polyline state
	logic [CW-1:0]      count_q;
	logic               complete_q;
	angle_t             prev_q;
	coord_t             last_x_q, last_y_q;
	logic [AW-1:0]      idx_q;

	// cordic
	logic signed [27:0] cx_q, cy_q;
	logic signed [19:0] cz_q;
	logic               zero_q;
	angle_t             s_q;

	// query
	logic signed [17:0] px_q, py_q;
	logic [CW-1:0]      k_q;
	logic [34:0]        sq_q, s1_q, s2_q;
	logic [AW-1:0]      b1_q, b2_q;
	angle_t             a1_q, a2_q;
	logic [51:0]        rad_q;
	logic [25:0]        root_q, d1_q, d2_q;
	logic [27:0]        srem_q;
	logic               second_q;
	logic signed [42:0] num_q;
	logic signed [53:0] prod_q;
	logic [42:0]        quo_q;
	logic [26:0]        drem_q;
	logic               neg_q;

	// result
	angle_t  res_q;
	status_t stat_q;
	logic    out_valid_q;
	angle_t  out_angle_q;
	status_t out_status_q;

	// ram ports
	logic          xy_we, xy_re, ang_we, ang_re;
	logic [AW-1:0] xy_waddr, ang_waddr, ang_raddr;
	angle_t        ang_wdata;
	logic [15:0]   rx, ry, rang;

	pdfi_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_ram_x (
		.clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(req.coord_x),
		.re(xy_re), .raddr(k_q[AW-1:0]), .rdata_q(rx)
	);
	pdfi_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_ram_y (
		.clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(req.coord_y),
		.re(xy_re), .raddr(k_q[AW-1:0]), .rdata_q(ry)
	);
	pdfi_ram #(.WIDTH(16), .DEPTH(MAX_VERTICES)) u_ram_ang (
		.clk(clk), .we(ang_we), .waddr(ang_waddr), .wdata(ang_wdata),
		.re(ang_re), .raddr(ang_raddr), .rdata_q(rang)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid  = out_valid_q;
	assign rsp.angle  = out_angle_q;
	assign rsp.status = out_status_q;

	logic accept;
	assign accept = req.valid && (state_q == S_IDLE);

	// load-side decode
	logic [CW-1:0] cnt_eff;
	logic          full;
	logic signed [16:0] ldx, ldy;
	logic signed [27:0] x0, y0;
	assign cnt_eff = complete_q ? '0 : count_q;
	assign full    = (cnt_eff >= CW'(MAX_VERTICES));
	assign ldx = 17'(req.coord_x) - 17'(last_x_q);
	assign ldy = 17'(req.coord_y) - 17'(last_y_q);
	assign x0  = {{3{ldx[16]}}, ldx, 8'b0};
	assign y0  = {{3{ldy[16]}}, ldy, 8'b0};

	// query clamp
	logic signed [16:0] relx, rely;
	logic [15:0]        hix, hiy;
	logic signed [17:0] clx, cly;
	assign relx = 17'(req.coord_x) - 17'(origin_x_q);
	assign rely = 17'(req.coord_y) - 17'(origin_y_q);
	assign hix  = (field_w_q == 16'd0) ? 16'd0 : field_w_q - 16'd1;
	assign hiy  = (field_h_q == 16'd0) ? 16'd0 : field_h_q - 16'd1;
	always_comb begin
		priority if (relx < 0) clx = '0;
		else if (18'(relx) > $signed({2'b0, hix})) clx = $signed({2'b0, hix});
		else clx = 18'(relx);
		priority if (rely < 0) cly = '0;
		else if (18'(rely) > $signed({2'b0, hiy})) cly = $signed({2'b0, hiy});
		else cly = 18'(rely);
	end

	// cordic step and rounding
	logic signed [27:0] xs, ys;
	logic signed [19:0] atan_s, zr, zsat;
	logic signed [16:0] msum;
	angle_t             s_now;
	assign xs     = cx_q >>> iter_q[4:0];
	assign ys     = cy_q >>> iter_q[4:0];
	assign atan_s = $signed({4'b0, cordic_atan(iter_q[4:0])});
	assign zr     = (cz_q + 20'sd4) >>> 3;
	always_comb begin
		priority if (zr > ANGLE_MAX) zsat = ANGLE_MAX;
		else if (zr < -ANGLE_MAX) zsat = -ANGLE_MAX;
		else zsat = zr;
	end
	assign s_now = zero_q ? '0 : zsat[15:0];
	assign msum  = 17'(prev_q) + 17'(s_now);

	// shared multiplier
	logic signed [26:0] mul_a, mul_b;
	logic signed [53:0] mul_p;
	logic signed [18:0] dxq, dyq;
	assign dxq = 19'($signed(rx)) - 19'(px_q);
	assign dyq = 19'($signed(ry)) - 19'(py_q);
	always_comb begin
		unique case (state_q)
			S_QMX:   begin mul_a = 27'(dxq); mul_b = 27'(dxq); end
			S_QMY:   begin mul_a = 27'(dyq); mul_b = 27'(dyq); end
			S_M1:    begin mul_a = 27'(a1_q); mul_b = $signed({1'b0, d2_q}); end
			S_M2:    begin mul_a = 27'(a2_q); mul_b = $signed({1'b0, d1_q}); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// scan compare
	logic [34:0] sq_sum;
	assign sq_sum = sq_q + prod_q[34:0];

	// square root step
	logic [27:0] rsh, trial;
	assign rsh   = {srem_q[25:0], rad_q[51:50]};
	assign trial = {root_q, 2'b01};

	// divide step
	logic [26:0] den;
	logic [27:0] dsh;
	logic signed [42:0] num_sum;
	logic        div_ge;
	logic [15:0] quo_new;
	assign den     = 27'(d1_q) + 27'(d2_q);
	assign dsh     = {drem_q, quo_q[42]};
	assign num_sum = num_q + prod_q[42:0];
	assign div_ge  = (dsh >= {1'b0, den});
	assign quo_new = {quo_q[14:0], div_ge};

	// ram port control
	always_comb begin
		xy_we     = 1'b0;
		xy_waddr  = cnt_eff[AW-1:0];
		xy_re     = (state_q == S_QRD);
		ang_we    = 1'b0;
		ang_waddr = cnt_eff[AW-1:0];
		ang_wdata = '0;
		ang_re    = (state_q == S_QA1) || (state_q == S_QA2);
		ang_raddr = (state_q == S_QA1) ? b1_q : b2_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.command == CMD_LOAD && !full) begin
					xy_we  = 1'b1;
					ang_we = (cnt_eff == '0);
				end
			end
			S_WA0: begin
				ang_we    = 1'b1;
				ang_waddr = idx_q - AW'(1);
				ang_wdata = (idx_q == AW'(1)) ? s_now : msum[16:1];
			end
			S_WA1: begin
				ang_we    = 1'b1;
				ang_waddr = idx_q;
				ang_wdata = s_q;
			end
			default: ;
		endcase
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			field_w_q  <= 16'd1024;
			field_h_q  <= 16'd1024;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ORIGIN_X:     origin_x_q <= cfg.data;
				CFG_ORIGIN_Y:     origin_y_q <= cfg.data;
				CFG_FIELD_WIDTH:  field_w_q  <= cfg.data;
				CFG_FIELD_HEIGHT: field_h_q  <= cfg.data;
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iter_q     <= '0;
			count_q    <= '0;
			complete_q <= 1'b0;
			prev_q     <= '0;
			k_q        <= '0;
			second_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						iter_q <= '0;
						k_q    <= '0;
						if (req.command == CMD_LOAD) begin
							complete_q <= req.last_point;
							if (complete_q) prev_q <= '0;
							if (full) begin
								count_q <= cnt_eff;
								state_q <= S_DONE;
							end else begin
								count_q <= cnt_eff + CW'(1);
								state_q <= (cnt_eff == '0) ? S_DONE : S_CORD;
							end
						end else if (!complete_q || count_q < CW'(2)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_QRD;
						end
					end
				end
				S_CORD: begin
					iter_q <= iter_q + 6'd1;
					if (iter_q == 6'(CORDIC_ITERS - 1)) state_q <= S_WA0;
				end
				S_WA0: state_q <= S_WA1;
				S_WA1: begin
					prev_q  <= s_q;
					state_q <= S_DONE;
				end
				S_QRD:  state_q <= S_QMX;
				S_QMX:  state_q <= S_QMY;
				S_QMY:  state_q <= S_QCMP;
				S_QCMP: begin
					k_q     <= k_q + CW'(1);
					state_q <= (k_q + CW'(1) == count_q) ? S_QA1 : S_QRD;
				end
				S_QA1: state_q <= S_QA2;
				S_QA2: begin
					iter_q   <= '0;
					second_q <= 1'b0;
					state_q  <= S_SQRT;
				end
				S_SQRT: begin
					if (iter_q == SQRT_STEPS) begin
						iter_q   <= '0;
						second_q <= 1'b1;
						if (second_q) state_q <= S_M1;
					end else begin
						iter_q <= iter_q + 6'd1;
					end
				end
				S_M1: state_q <= (den == '0) ? S_DONE : S_M2;
				S_M2: state_q <= S_M3;
				S_M3: begin
					iter_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					iter_q <= iter_q + 6'd1;
					if (iter_q == DIV_STEPS - 6'd1) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				res_q  <= '0;
				idx_q  <= cnt_eff[AW-1:0];
				zero_q <= (ldx == 0) && (ldy == 0);
				px_q   <= 18'(origin_x_q) + clx;
				py_q   <= 18'(origin_y_q) + cly;
				s1_q   <= '1;
				s2_q   <= '1;
				b1_q   <= '0;
				b2_q   <= AW'(1);
				if (req.command == CMD_LOAD) begin
					stat_q <= full ? STATUS_FULL : STATUS_OK;
					if (accept && !full) begin
						last_x_q <= req.coord_x;
						last_y_q <= req.coord_y;
					end
				end else begin
					stat_q <= (!complete_q || count_q < CW'(2)) ? STATUS_EMPTY : STATUS_OK;
				end
				// fold into the right half plane
				if (x0 < 0) begin
					if (y0 >= 0) begin
						cx_q <= y0; cy_q <= -x0; cz_q <= HALF_PI_Q16;
					end else begin
						cx_q <= -y0; cy_q <= x0; cz_q <= -HALF_PI_Q16;
					end
				end else begin
					cx_q <= x0; cy_q <= y0; cz_q <= '0;
				end
			end
			S_CORD: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + atan_s;
				end else begin
					cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - atan_s;
				end
			end
			S_WA0: s_q <= s_now;
			S_QMX: prod_q <= mul_p;
			S_QMY: begin
				sq_q   <= prod_q[34:0];
				prod_q <= mul_p;
			end
			S_QCMP: begin
				// keep the two smallest, lower index on ties
				if (sq_sum < s1_q) begin
					s2_q <= s1_q; b2_q <= b1_q;
					s1_q <= sq_sum; b1_q <= k_q[AW-1:0];
				end else if (sq_sum < s2_q) begin
					s2_q <= sq_sum; b2_q <= k_q[AW-1:0];
				end
			end
			S_QA2: begin
				a1_q   <= rang;
				rad_q  <= {1'b0, s1_q, 16'b0};
				root_q <= '0;
				srem_q <= '0;
			end
			S_SQRT: begin
				if (iter_q == SQRT_STEPS) begin
					if (!second_q) d1_q <= root_q;
					else d2_q <= root_q;
					if (!second_q) a2_q <= rang;
					rad_q  <= {1'b0, s2_q, 16'b0};
					root_q <= '0;
					srem_q <= '0;
				end else begin
					rad_q <= {rad_q[49:0], 2'b00};
					if (rsh >= trial) begin
						srem_q <= rsh - trial;
						root_q <= {root_q[24:0], 1'b1};
					end else begin
						srem_q <= rsh;
						root_q <= {root_q[24:0], 1'b0};
					end
				end
			end
			S_M1: begin
				res_q <= a1_q;
				num_q <= mul_p[42:0];
			end
			S_M2: prod_q <= mul_p;
			S_M3: begin
				neg_q  <= num_sum[42];
				quo_q  <= num_sum[42] ? 43'(-num_sum) : 43'(num_sum);
				drem_q <= '0;
			end
			S_DIV: begin
				if (div_ge) begin
					drem_q <= 27'(dsh - {1'b0, den});
					quo_q  <= {quo_q[41:0], 1'b1};
				end else begin
					drem_q <= dsh[26:0];
					quo_q  <= {quo_q[41:0], 1'b0};
				end
				// last step: take the quotient with its final bit
				if (iter_q == DIV_STEPS - 6'd1) begin
					res_q <= neg_q ? -quo_new : quo_new;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_angle_q  <= (stat_q == STATUS_OK) ? res_q : '0;
			out_status_q <= stat_q;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/pdfi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdfi_checker: port-level checks of the direction field interpolator
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pdfi_checker import pdfi_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    req_valid,
	input wire logic    req_ready,
	input wire logic    rsp_valid,
	input wire logic    rsp_ready,
	input wire angle_t  rsp_angle,
	input wire status_t rsp_status
);
	// a result word never carries an unused status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_EMPTY ||
			rsp_status == STATUS_FULL))
		else $error("unused status code on result");

	// results with a non-OK status carry a zero angle
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != STATUS_OK) |-> (rsp_angle == '0))
		else $error("non-zero angle with error status");

	// angles stay within plus and minus pi
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_angle <= 16'sd25736 && rsp_angle >= -16'sd25736))
		else $error("angle out of range");

	// the block is busy in the cycle after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken twice in a row");

	// a waiting result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_angle) && $stable(rsp_status)))
		else $error("result dropped or changed while stalled");
endmodule

bind polyline_direction_field_interp_core pdfi_checker u_pdfi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_angle(rsp.angle),
	.rsp_status(rsp.status)
);
`default_nettype wire
